// File: design/dtrc_pkg.sv
`default_nettype none
package dtrc_pkg;

  localparam int MANT_W    = 53;
  localparam int CONV_W    = 40;
  localparam int PROD_W    = 93;
  localparam int LIMIT_W   = 31;
  localparam int THR_W     = 85;
  localparam int DIGIT_W   = 8;
  localparam int MUL_STEPS = 5;
  localparam int DIV_STEPS = 56;

  localparam logic [LIMIT_W-1:0] RESET_LIMIT    = 31'd1000000000;
  localparam logic [63:0]        STOP_FRAC_BITS = 64'h3EB0C6F7A0B5ED8D;

  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [CONV_W-1:0] conv_t;
  typedef logic [PROD_W-1:0] prod_t;

endpackage
`default_nettype wire

// File: design/dtrc_mul.sv
`default_nettype none
module dtrc_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dtrc_pkg::mant_t op_a,
  input  wire dtrc_pkg::conv_t op_b,
  output logic                 done,
  output dtrc_pkg::prod_t      prod
);

  logic            run;
  logic [2:0]      cnt;
  dtrc_pkg::prod_t ash;
  dtrc_pkg::conv_t bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(dtrc_pkg::MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one 8-bit digit of op_b per cycle, shift-add into the accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      ash  <= dtrc_pkg::PROD_W'(op_a);
      bsh  <= op_b;
    end else if (run) begin
      prod <= prod + ash * dtrc_pkg::PROD_W'(bsh[dtrc_pkg::DIGIT_W-1:0]);
      ash  <= ash << dtrc_pkg::DIGIT_W;
      bsh  <= bsh >> dtrc_pkg::DIGIT_W;
    end
  end

endmodule
`default_nettype wire

// File: design/double_to_rational_convergents.sv
// specials go straight to the finish state, else the sequencer runs convergent steps
// plus the partial last step; a step is four passes through the shared 53x8
// shift-add multiplier, a reciprocal divider and a normalize loop
// throughput: one request at a time, busy drops in the cycle that done pulses
// results show for one cycle on done; the receiver cannot stall
// synchronous reset: sequencer idle, limit back to 1000000000
`default_nettype none
module double_to_rational_convergents (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [63:0]        value_bits,
  input  wire logic               magnitude_limit_we,
  input  wire logic [30:0]        magnitude_limit,
  output logic                    done,
  output logic signed [32:0]      numerator,
  output logic [31:0]             denominator
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MP    = 4'd1;
  localparam logic [3:0] S_MPW   = 4'd2;
  localparam logic [3:0] S_MQ    = 4'd3;
  localparam logic [3:0] S_MQW   = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_AP    = 4'd6;
  localparam logic [3:0] S_APW   = 4'd7;
  localparam logic [3:0] S_AQ    = 4'd8;
  localparam logic [3:0] S_AQW   = 4'd9;
  localparam logic [3:0] S_NORM  = 4'd10;
  localparam logic [3:0] S_FCHK  = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_RND   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0]      state;
  logic [30:0]     lim;
  logic            neg;
  logic [10:0]     xe;
  dtrc_pkg::mant_t xm;
  dtrc_pkg::conv_t p, q, pp, qp;
  logic [31:0]     ai;
  logic [84:0]     thr;
  logic [53:0]     dr;
  logic [55:0]     dq;
  logic [5:0]      dcnt;

  logic            mul_start;
  logic            mul_done;
  dtrc_pkg::mant_t mul_a;
  dtrc_pkg::conv_t mul_b;
  dtrc_pkg::prod_t prod;

  assign busy = (state != S_IDLE);

  always_comb begin
    mul_start = (state == S_MP) || (state == S_MQ) || (state == S_AP) || (state == S_AQ);
    mul_a     = ((state == S_AP) || (state == S_AQ)) ? dtrc_pkg::MANT_W'(ai) : xm;
    mul_b     = ((state == S_MQ) || (state == S_AQ)) ? q : p;
  end

  dtrc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // rounding threshold of the limit, scaled by 2^54: below it a product rounds under the limit
  logic [4:0]  lk;
  logic        pow2;
  logic [84:0] thr_new;
  always_comb begin
    lk = '0;
    for (int i = 0; i < 31; i++) begin
      if (lim[i]) lk = 5'(i);
    end
    pow2    = ((lim & (lim - 31'd1)) == '0);
    thr_new = {lim, 54'b0} - (85'd1 << (pow2 ? {1'b0, lk} : ({1'b0, lk} + 6'd1)));
  end

  // exact compare of mantissa product against threshold
  logic signed [12:0] rsh;
  logic signed [12:0] nsh;
  logic               lt_lim;
  always_comb begin
    rsh    = 13'sd1021 - $signed({2'b0, xe});
    nsh    = -rsh;
    lt_lim = 1'b0;
    if (!rsh[12]) begin
      if (rsh > 13'sd127) begin
        lt_lim = 1'b1;
      end else begin
        lt_lim = (prod >> rsh[6:0]) < dtrc_pkg::PROD_W'(thr);
      end
    end else begin
      if (nsh >= 13'sd85) begin
        lt_lim = (prod == '0);
      end else begin
        lt_lim = prod <= dtrc_pkg::PROD_W'((thr - 85'd1) >> nsh[6:0]);
      end
    end
  end

  // integer part and fraction
  logic [10:0]     ssh;
  dtrc_pkg::mant_t fmask;
  logic [31:0]     a_split;
  dtrc_pkg::mant_t f_split;
  always_comb begin
    ssh     = 11'd1075 - xe;
    fmask   = (dtrc_pkg::MANT_W'(1) << ssh[5:0]) - dtrc_pkg::MANT_W'(1);
    a_split = 32'(xm >> ssh[5:0]);
    f_split = xm & fmask;
  end

  logic [53:0] dtry;
  logic        dge;
  logic [52:0] rmant;
  logic        rup;
  logic [53:0] rsum;
  logic        f_small;
  always_comb begin
    dtry    = {dr[52:0], 1'b0};
    dge     = dtry >= {1'b0, xm};
    rmant   = dq[54:2];
    rup     = dq[1] & (dq[0] | (dr != '0) | rmant[0]);
    rsum    = {1'b0, rmant} + 54'(rup);
    f_small = (xm == '0) || ({xe, xm[51:0]} < dtrc_pkg::STOP_FRAC_BITS[62:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      lim   <= dtrc_pkg::RESET_LIMIT;
    end else begin
      done <= 1'b0;
      if (magnitude_limit_we) lim <= magnitude_limit;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= ((&value_bits[62:52]) || (lim == '0)) ? S_FIN : S_MP;
          end
        end
        S_MP:    state <= S_MPW;
        S_MPW:   if (mul_done) state <= lt_lim ? S_MQ : S_FIN;
        S_MQ:    state <= S_MQW;
        S_MQW:   if (mul_done) state <= lt_lim ? S_SPLIT : S_FIN;
        S_SPLIT: state <= (xe >= 11'd1055) ? S_FIN : S_AP;
        S_AP:    state <= S_APW;
        S_APW:   if (mul_done) state <= S_AQ;
        S_AQ:    state <= S_AQW;
        S_AQW:   if (mul_done) state <= S_NORM;
        S_NORM:  if ((xm == '0) || xm[52] || (xe == 11'd1)) state <= S_FCHK;
        S_FCHK:  state <= f_small ? S_FIN : S_DIV;
        S_DIV:   if (dcnt == 6'(dtrc_pkg::DIV_STEPS - 1)) state <= S_RND;
        S_RND:   state <= S_MP;
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          neg <= value_bits[63] & (value_bits[62:0] != '0)
                 & !((&value_bits[62:52]) & (value_bits[51:0] != '0));
          p   <= dtrc_pkg::CONV_W'(1);
          q   <= '0;
          pp  <= '0;
          qp  <= dtrc_pkg::CONV_W'(1);
          thr <= thr_new;
          // subnormals keep exponent 1 without the hidden bit
          xe  <= (value_bits[62:52] == '0) ? 11'd1 : value_bits[62:52];
          xm  <= {(value_bits[62:52] != '0), value_bits[51:0]};
        end
      end
      S_SPLIT: begin
        if (xe >= 11'd1023) begin
          ai <= a_split;
          xm <= f_split;
        end else begin
          ai <= '0;
        end
      end
      S_APW: begin
        if (mul_done) begin
          p  <= prod[dtrc_pkg::CONV_W-1:0] + pp;
          pp <= p;
        end
      end
      S_AQW: begin
        if (mul_done) begin
          q  <= prod[dtrc_pkg::CONV_W-1:0] + qp;
          qp <= q;
        end
      end
      S_NORM: begin
        if (!((xm == '0) || xm[52] || (xe == 11'd1))) begin
          if (xm[52:45] == '0) begin
            xm <= xm << 8;
            xe <= xe - 11'd8;
          end else begin
            xm <= xm << 1;
            xe <= xe - 11'd1;
          end
        end
      end
      S_FCHK: begin
        dr   <= 54'd1 << 51;
        dq   <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        dr   <= dge ? (dtry - {1'b0, xm}) : dtry;
        dq   <= {dq[54:0], dge};
        dcnt <= dcnt + 6'd1;
      end
      S_RND: begin
        // reciprocal mantissa with round to nearest even
        if (dq[55] || rsum[53]) begin
          xm <= dtrc_pkg::MANT_W'(1) << 52;
          xe <= 11'd2046 - xe;
        end else begin
          xm <= rsum[52:0];
          xe <= 11'd2045 - xe;
        end
      end
      S_FIN: begin
        numerator   <= neg ? $signed(33'd0 - p[32:0]) : $signed(p[32:0]);
        denominator <= q[31:0];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
